>>> sv/qte_pkg.sv
// package: shared types, constants and the arctangent table for the quaternion to euler block
package qte_pkg;

    localparam int TERM_W   = 36;
    localparam int CORD_W   = 38;
    localparam int ACC_W    = 34;
    localparam int ANG_W    = 18;
    localparam int ROOT_W   = 29;
    localparam int SQ_W     = 58;
    localparam int SQRT_LAT = 31;
    localparam int ATAN_LEN = 24;

    localparam logic signed [15:0] HALF_PI_BA = 16'sd16384;

    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [ANG_W-1:0]  t_ang;

    typedef struct packed {
        t_term roll_n;
        t_term roll_d;
        t_term yaw_n;
        t_term yaw_d;
        t_term s;
        logic  s_hi;
        logic  s_lo;
    } t_side;

    typedef struct packed {
        logic s_hi;
        logic s_lo;
    } t_pflag;

    function automatic logic signed [ACC_W-1:0] qte_atan(input int idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:  v = 34'sh020000000;
            1:  v = 34'sh012E4051D;
            2:  v = 34'sh009FB385B;
            3:  v = 34'sh0051111D4;
            4:  v = 34'sh0028B0D43;
            5:  v = 34'sh00145D7E1;
            6:  v = 34'sh000A2F61E;
            7:  v = 34'sh000517C55;
            8:  v = 34'sh00028BE53;
            9:  v = 34'sh000145F2E;
            10: v = 34'sh0000A2F98;
            11: v = 34'sh0000517CC;
            12: v = 34'sh000028BE6;
            13: v = 34'sh0000145F3;
            14: v = 34'sh00000A2F9;
            15: v = 34'sh00000517C;
            16: v = 34'sh0000028BE;
            17: v = 34'sh00000145F;
            18: v = 34'sh000000A2F;
            19: v = 34'sh000000517;
            20: v = 34'sh00000028B;
            21: v = 34'sh000000145;
            22: v = 34'sh0000000A2;
            23: v = 34'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/qte_quat_if.sv
// interface: quaternion request channel
interface qte_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

>>> sv/qte_euler_if.sv
// interface: euler angle result channel
interface qte_euler_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

>>> sv/qte_terms.sv
// rotation matrix terms: component products, then sums and asin range flags
module qte_terms (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic signed [15:0] i_z,
    input  logic signed [15:0] i_w,
    output qte_pkg::t_side     o_side
);
    import qte_pkg::*;

    logic signed [31:0] r_ww, r_xx, r_yy, r_zz, r_yz, r_wx, r_xy, r_wz, r_wy, r_xz;
    t_side r_side;
    t_term n_s;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ww <= i_w * i_w;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_yz <= i_y * i_z;
            r_wx <= i_w * i_x;
            r_xy <= i_x * i_y;
            r_wz <= i_w * i_z;
            r_wy <= i_w * i_y;
            r_xz <= i_x * i_z;
        end
    end

    assign n_s = (t_term'(r_wy) - t_term'(r_xz)) <<< 1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side.roll_n <= (t_term'(r_yz) + t_term'(r_wx)) <<< 1;
            r_side.roll_d <= t_term'(r_ww) - t_term'(r_xx) - t_term'(r_yy) + t_term'(r_zz);
            r_side.yaw_n  <= (t_term'(r_xy) + t_term'(r_wz)) <<< 1;
            r_side.yaw_d  <= t_term'(r_ww) + t_term'(r_xx) - t_term'(r_yy) - t_term'(r_zz);
            r_side.s      <= n_s;
            r_side.s_hi   <= n_s >= (t_term'(1) <<< 28);
            r_side.s_lo   <= n_s <= -(t_term'(1) <<< 28);
        end
    end

    assign o_side = r_side;
endmodule

>>> sv/qte_sqrt.sv
// pipelined square root of one minus the squared asin argument, one root bit per stage
module qte_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  qte_pkg::t_term                i_s,
    output logic [qte_pkg::ROOT_W-1:0]    o_root
);
    import qte_pkg::*;

    localparam int NST = ROOT_W;

    logic signed [SQ_W-1:0] r_ss;
    logic [SQ_W-1:0]        r_n [0:NST];
    logic [SQ_W-1:0]        r_r [0:NST];
    logic signed [ROOT_W-1:0] s_lo;

    assign s_lo = i_s[ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ss   <= s_lo * s_lo;
            r_n[0] <= (SQ_W'(1) << 56) - SQ_W'(r_ss);
            r_r[0] <= '0;
        end
    end

    for (genvar j = 0; j < NST; j++) begin : g_st
        localparam int K = NST - 1 - j;
        logic [SQ_W:0] n_sum;
        assign n_sum = {1'b0, r_r[j]} + ((SQ_W+1)'(1) << (2*K));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, r_n[j]} >= n_sum) begin
                    r_n[j+1] <= r_n[j] - n_sum[SQ_W-1:0];
                    r_r[j+1] <= (r_r[j] >> 1) + (SQ_W'(1) << (2*K));
                end else begin
                    r_n[j+1] <= r_n[j];
                    r_r[j+1] <= r_r[j] >> 1;
                end
            end
        end
    end

    assign o_root = r_r[NST][ROOT_W-1:0];
endmodule

>>> sv/qte_cordic.sv
// vectoring cordic pipeline: atan2 as a binary angle before wrapping
module qte_cordic #(
    parameter int STAGES = 16
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  qte_pkg::t_term i_y,
    input  qte_pkg::t_term i_x,
    output qte_pkg::t_ang  o_angle
);
    import qte_pkg::*;

    localparam int NIT = (STAGES < ATAN_LEN) ? STAGES : ATAN_LEN;

    logic signed [CORD_W-1:0] r_x [0:NIT];
    logic signed [CORD_W-1:0] r_y [0:NIT];
    logic signed [ACC_W-1:0]  r_a [0:NIT];
    logic                     r_z [0:NIT];
    t_ang                     r_out;
    logic signed [CORD_W-1:0] xe, ye;
    logic signed [ACC_W-1:0]  n_rnd;

    assign xe = CORD_W'(i_x);
    assign ye = CORD_W'(i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0] <= (i_x == '0) && (i_y == '0);
            if (xe < 0 && ye >= 0) begin
                r_x[0] <= ye;
                r_y[0] <= -xe;
                r_a[0] <= ACC_W'(1) <<< 30;
            end else if (xe < 0) begin
                r_x[0] <= -ye;
                r_y[0] <= xe;
                r_a[0] <= -(ACC_W'(1) <<< 30);
            end else begin
                r_x[0] <= xe;
                r_y[0] <= ye;
                r_a[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < NIT; i++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z[i+1] <= r_z[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_a[i+1] <= r_a[i] + qte_atan(i);
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_a[i+1] <= r_a[i] - qte_atan(i);
                end
            end
        end
    end

    assign n_rnd = (r_a[NIT] + ACC_W'(32768)) >>> 16;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_z[NIT] ? '0 : n_rnd[ANG_W-1:0];
        end
    end

    assign o_angle = r_out;
endmodule

>>> sv/quaternion_to_euler_angles.sv
// top level: quaternion to zyx euler angles, fully pipelined
// usage:
//   i_quat carries one quaternion (x, y, z, w), signed q1.14, per request.
//   o_euler returns roll, pitch and yaw as signed binary angles, 32768 = pi.
//   every request gives exactly one result, in order.
// throughput: one request per cycle while o_euler is not stalled.
// pipeline: from acceptance to o_euler.valid, two product and sum stages,
//   31 square root stages, then the cordic pre-rotation, CORDIC_STAGES
//   iterations (at most ATAN_LEN) and a rounding stage.
// pitch saturates at plus or minus pi/2 when the quaternion is not normalized.
// reset clears every valid bit; data registers are not reset.
// when the receiver stalls with a result waiting, the whole pipeline holds
//   and i_quat.ready drops; nothing is lost or repeated.
// i_quat.ready stays high while the output stage is empty or being taken.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qte_quat_if.sink    i_quat,
    qte_euler_if.source o_euler
);
    import qte_pkg::*;

    localparam int CLAT = CORDIC_STAGES + 2;
    localparam int LAT  = 2 + SQRT_LAT + CLAT;

    logic               en;
    logic [LAT-1:0]     r_vld;
    t_side              side0;
    t_side              r_side [0:SQRT_LAT-1];
    t_pflag             r_pf   [0:CLAT-1];
    logic [ROOT_W-1:0]  root;
    t_ang               roll_a, pitch_a, yaw_a;
    t_side              sd;
    logic signed [15:0] pitch_c;

    assign en          = !r_vld[LAT-1] || o_euler.ready;
    assign i_quat.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_quat.valid};
        end
    end

    qte_terms u_terms (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (i_quat.quat_x),
        .i_y    (i_quat.quat_y),
        .i_z    (i_quat.quat_z),
        .i_w    (i_quat.quat_w),
        .o_side (side0)
    );

    qte_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_s    (side0.s),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= side0;
            for (int k = 1; k < SQRT_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_pf[0] <= '{s_hi: r_side[SQRT_LAT-1].s_hi, s_lo: r_side[SQRT_LAT-1].s_lo};
            for (int k = 1; k < CLAT; k++) begin
                r_pf[k] <= r_pf[k-1];
            end
        end
    end

    assign sd = r_side[SQRT_LAT-1];

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk (i_clk), .i_en (en), .i_y (sd.roll_n), .i_x (sd.roll_d), .o_angle (roll_a)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk (i_clk), .i_en (en), .i_y (sd.yaw_n), .i_x (sd.yaw_d), .o_angle (yaw_a)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk (i_clk), .i_en (en), .i_y (sd.s), .i_x (t_term'({1'b0, root})),
        .o_angle (pitch_a)
    );

    always_comb begin
        if (r_pf[CLAT-1].s_hi || pitch_a > t_ang'(HALF_PI_BA)) begin
            pitch_c = HALF_PI_BA;
        end else if (r_pf[CLAT-1].s_lo || pitch_a < -t_ang'(HALF_PI_BA)) begin
            pitch_c = -HALF_PI_BA;
        end else begin
            pitch_c = pitch_a[15:0];
        end
    end

    assign o_euler.valid       = r_vld[LAT-1];
    assign o_euler.roll_angle  = roll_a[15:0];
    assign o_euler.pitch_angle = pitch_c;
    assign o_euler.yaw_angle   = yaw_a[15:0];
endmodule
